FILE: rtl/five_tuple_flow_counter_assert.svh
// Assertion macros used by the flow counter datapath.
`ifndef FIVE_TUPLE_FLOW_COUNTER_ASSERT_SVH
`define FIVE_TUPLE_FLOW_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FTFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flow counter assertion failed");
`define FTFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flow counter assertion failed");
`else
`define FTFC_ASSERT(lbl, prop)
`define FTFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ftfc_pkg.sv
// Types and constants of the five-tuple flow counter.
package ftfc_pkg;
  localparam int KEY_BITS = 104;
  localparam int OUT_LEN_BITS = 16;
  localparam logic [15:0] IPV4_TYPE = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic parse_en;
    logic reject;
    logic latch;
    logic rd_key;
    logic inc_idx;
    logic rd_cnt;
    logic wr_new;
    logic wr_upd;
    logic out_full;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic table_empty;
    logic table_full;
    logic idx_last;
    logic key_match;
    logic out_busy;
  } stat_t;
endpackage

FILE: rtl/ftfc_ctrl.sv
// Controller state machine of the flow counter.
module ftfc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_byte,
  output logic           in_stall,
  input  ftfc_pkg::stat_t stat,
  output ftfc_pkg::cmd_t  cmd
);
  import ftfc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_RD   = 6'b000100,
    S_CMP  = 6'b001000,
    S_MISS = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE) || (stat.out_busy && in_last_byte);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.parse_en = accept;
        if (accept && in_last_byte) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.frame_ok) begin
          cmd.reject = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.latch = 1'b1;
          state_nxt = stat.table_empty ? S_MISS : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_key = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.key_match) begin
          cmd.rd_cnt = 1'b1;
          state_nxt = S_UPD;
        end else if (stat.idx_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MISS: begin
        if (stat.table_full) cmd.out_full = 1'b1;
        else cmd.wr_new = 1'b1;
        state_nxt = S_IDLE;
      end
      S_UPD: begin
        cmd.wr_upd = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: rtl/ftfc_datapath.sv
// Header parser, flow table, counters and result register of the flow counter.
`include "five_tuple_flow_counter_assert.svh"
module ftfc_datapath #(
  parameter int TABLE_ENTRIES = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ftfc_pkg::cmd_t        cmd,
  output ftfc_pkg::stat_t       stat,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [7:0]            out_flow_slot,
  output logic [63:0]           out_packet_total,
  output logic [63:0]           out_byte_total,
  output logic [15:0]           out_frame_length
);
  import ftfc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  logic [LB-1:0] off_r, off_nxt;
  logic [15:0] et_r, et_nxt;
  logic [3:0] hw_r, hw_nxt;
  logic [7:0] proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [15:0] sport_r, sport_nxt, dport_r, dport_nxt;
  logic [LB-1:0] l4_cur, l4_r, need;
  logic is_tcp, is_udp, l4_proto;
  logic [KEY_BITS-1:0] key_cur, key_f_r, key_q;
  logic [LB-1:0] len_f_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
  logic [63:0] pkt_mem [TABLE_ENTRIES];
  logic [63:0] byt_mem [TABLE_ENTRIES];
  logic [63:0] pkt_q, byt_q;
  logic [IW-1:0] wr_addr;
  logic [63:0] pkt_wr, byt_wr;
  logic out_load;
  status_t status_nxt;
  logic out_valid_r;
  status_t status_r;
  logic [7:0] slot_r;
  logic [63:0] pkt_r, byt_r;
  logic [15:0] flen_r;

  always_comb begin
    off_nxt = off_r;
    et_nxt = et_r;
    hw_nxt = hw_r;
    proto_nxt = proto_r;
    src_nxt = src_r;
    dst_nxt = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    if (off_r == LB'(12) || off_r == LB'(13)) et_nxt = {et_r[7:0], in_data_byte};
    if (off_r == LB'(14)) hw_nxt = in_data_byte[3:0];
    if (off_r == LB'(23)) proto_nxt = in_data_byte;
    if (off_r >= LB'(26) && off_r <= LB'(29)) src_nxt = {src_r[23:0], in_data_byte};
    if (off_r >= LB'(30) && off_r <= LB'(33)) dst_nxt = {dst_r[23:0], in_data_byte};
    l4_cur = LB'(14) + LB'({hw_nxt, 2'b00});
    if (off_r >= LB'(14)) begin
      if (off_r == l4_cur || off_r == l4_cur + LB'(1))
        sport_nxt = {sport_r[7:0], in_data_byte};
      if (off_r == l4_cur + LB'(2) || off_r == l4_cur + LB'(3))
        dport_nxt = {dport_r[7:0], in_data_byte};
    end
    if (off_r < LEN_MAX) off_nxt = off_r + LB'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reject || cmd.latch) begin
      off_r <= '0;
      et_r <= '0;
      hw_r <= '0;
      proto_r <= '0;
      src_r <= '0;
      dst_r <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (cmd.parse_en) begin
      off_r <= off_nxt;
      et_r <= et_nxt;
      hw_r <= hw_nxt;
      proto_r <= proto_nxt;
      src_r <= src_nxt;
      dst_r <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

  assign l4_r = LB'(14) + LB'({hw_r, 2'b00});
  assign is_tcp = (proto_r == PROTO_TCP);
  assign is_udp = (proto_r == PROTO_UDP);
  assign l4_proto = is_tcp || is_udp;
  assign need = l4_r + (is_tcp ? LB'(20) : LB'(8));
  assign key_cur = l4_proto ? {src_r, dst_r, sport_r, dport_r, proto_r}
                            : {src_r, dst_r, 32'd0, proto_r};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_f_r <= key_cur;
      len_f_r <= off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.latch) idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + IW'(1);
      if (cmd.wr_new) count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) key_mem[wr_addr] <= key_f_r;
    if (cmd.rd_key) key_q <= key_mem[idx_r];
  end

  assign wr_addr = cmd.wr_new ? count_r[IW-1:0] : idx_r;
  assign pkt_wr = cmd.wr_new ? 64'd1 : pkt_q + 64'd1;
  assign byt_wr = (cmd.wr_new ? 64'd0 : byt_q) + 64'(len_f_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_new || cmd.wr_upd) begin
      pkt_mem[wr_addr] <= pkt_wr;
      byt_mem[wr_addr] <= byt_wr;
    end
    if (cmd.rd_cnt) begin
      pkt_q <= pkt_mem[idx_r];
      byt_q <= byt_mem[idx_r];
    end
  end

  assign stat.frame_ok = (et_r == IPV4_TYPE) && (off_r >= LB'(34)) &&
                         (!l4_proto || off_r >= need);
  assign stat.table_empty = (count_r == '0);
  assign stat.table_full = (count_r == CW'(TABLE_ENTRIES));
  assign stat.idx_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign stat.key_match = (key_q == key_f_r);
  assign stat.out_busy = out_valid_r;

  assign out_load = cmd.reject || cmd.out_full || cmd.wr_new || cmd.wr_upd;

  always_comb begin
    status_nxt = ST_REJECT;
    if (cmd.out_full) status_nxt = ST_FULL;
    else if (cmd.wr_new) status_nxt = ST_NEW;
    else if (cmd.wr_upd) status_nxt = ST_EXISTING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      if (cmd.wr_new || cmd.wr_upd) begin
        slot_r <= 8'(wr_addr);
        pkt_r <= pkt_wr;
        byt_r <= byt_wr;
      end else begin
        slot_r <= '0;
        pkt_r <= '0;
        byt_r <= '0;
      end
      flen_r <= cmd.reject ? OUT_LEN_BITS'(off_r) : OUT_LEN_BITS'(len_f_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_flow_slot = slot_r;
  assign out_packet_total = pkt_r;
  assign out_byte_total = byt_r;
  assign out_frame_length = flen_r;

  `FTFC_ASSERT(a_count_bound, count_r <= CW'(TABLE_ENTRIES))
  `FTFC_ASSERT(a_load_free, out_load |-> !out_valid_r)
  `FTFC_ASSERT(a_new_room, cmd.wr_new |-> !stat.table_full)
  `FTFC_ASSERT_NEXT(a_count_step, cmd.wr_new, count_r == $past(count_r) + CW'(1))
endmodule

FILE: rtl/five_tuple_flow_counter.sv
// Top level of the five-tuple flow counter.
// Frame bytes enter on the in_ channel, one byte per beat, with in_last_byte
// marking the final byte of a frame. Each frame yields exactly one result beat
// on the out_ channel: status, table slot, packet and byte totals of the flow,
// and the frame length saturated to LENGTH_BITS.
// Header bytes are taken one per cycle while in_stall is low. After the last
// byte, the key is compared against the stored flows one entry at a time, each
// entry taking a read state (S_RD) and a compare state (S_CMP), since the key
// memory has a registered read port. A rejected frame's result is loaded from
// S_EVAL, a new flow in an empty table goes through S_EVAL and S_MISS, and a
// miss or a hit on the newest entry searches all N stored entries; during that
// search the input channel is stalled.
// A completed result sits in an output register; bytes of the next frame are
// accepted while it waits, and only that frame's last byte is held back until
// the result beat has gone.
// Reset empties the flow table and clears the parser and the output valid.
// A stalled result holds its payload until out_stall falls.
module five_tuple_flow_counter #(
  parameter int TABLE_ENTRIES = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_flow_slot,
  output logic [63:0] out_packet_total,
  output logic [63:0] out_byte_total,
  output logic [15:0] out_frame_length
);
  import ftfc_pkg::*;

  cmd_t cmd;
  stat_t stat;

  ftfc_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_last_byte(in_last_byte),
    .in_stall(in_stall),
    .stat(stat),
    .cmd(cmd)
  );

  ftfc_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_flow_slot(out_flow_slot),
    .out_packet_total(out_packet_total),
    .out_byte_total(out_byte_total),
    .out_frame_length(out_frame_length)
  );
endmodule

FILE: tb/ftfc_flow_checker.sv
// Checker for the five-tuple flow counter: predicts each result beat and compares it.
`timescale 1ns / 1ps
module ftfc_flow_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_flow_slot,
  input  logic [63:0] out_packet_total,
  input  logic [63:0] out_byte_total,
  input  logic [15:0] out_frame_length,
  output int          errors,
  output int          pending
);
  import ftfc_pkg::*;

  localparam int FLOWS = 256;
  localparam int LEN_MAX = 65535;

  typedef struct {
    status_t     status;
    logic [7:0]  slot;
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [15:0] length;
  } flow_result_t;

  flow_result_t result_q[$];

  int           frame_offset;
  logic [15:0]  ether_type;
  logic [3:0]   header_words;
  logic [7:0]   ip_proto;
  logic [31:0]  src_addr;
  logic [31:0]  dst_addr;
  logic [15:0]  l4_src;
  logic [15:0]  l4_dst;
  int           flow_count;
  logic [103:0] key_store[FLOWS];
  logic [63:0]  flow_packets[FLOWS];
  logic [63:0]  flow_bytes[FLOWS];

  assign pending = result_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("Mismatch at %0t: %s got %0h, wanted %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic clear_frame();
    frame_offset = 0;
    ether_type = '0;
    header_words = '0;
    ip_proto = '0;
    src_addr = '0;
    dst_addr = '0;
    l4_src = '0;
    l4_dst = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int l4;
    int len;
    int slot;
    logic ok;
    logic [103:0] key;
    flow_result_t r;
    if (frame_offset == 12 || frame_offset == 13) ether_type = {ether_type[7:0], b};
    if (frame_offset == 14) header_words = b[3:0];
    if (frame_offset == 23) ip_proto = b;
    if (frame_offset >= 26 && frame_offset <= 29) src_addr = {src_addr[23:0], b};
    if (frame_offset >= 30 && frame_offset <= 33) dst_addr = {dst_addr[23:0], b};
    l4 = 14 + 4 * header_words;
    if (frame_offset >= 14) begin
      if (frame_offset == l4 || frame_offset == l4 + 1) l4_src = {l4_src[7:0], b};
      if (frame_offset == l4 + 2 || frame_offset == l4 + 3) l4_dst = {l4_dst[7:0], b};
    end
    if (frame_offset < LEN_MAX) frame_offset++;
    if (!last) return;
    len = frame_offset;
    ok = (ether_type == IPV4_TYPE) && (len >= 34);
    key = {src_addr, dst_addr, 16'h0, 16'h0, ip_proto};
    if (ok && (ip_proto == PROTO_TCP || ip_proto == PROTO_UDP)) begin
      if (len < l4 + ((ip_proto == PROTO_TCP) ? 20 : 8)) ok = 1'b0;
      else key = {src_addr, dst_addr, l4_src, l4_dst, ip_proto};
    end
    r.status = ST_REJECT;
    r.slot = '0;
    r.packets = '0;
    r.bytes = '0;
    r.length = len[15:0];
    if (ok) begin
      slot = flow_count;
      for (int i = 0; i < flow_count; i++) begin
        if (key_store[i] == key) begin
          slot = i;
          break;
        end
      end
      r.status = ST_EXISTING;
      if (slot >= flow_count) begin
        if (flow_count >= FLOWS) begin
          r.status = ST_FULL;
        end else begin
          key_store[slot] = key;
          flow_packets[slot] = '0;
          flow_bytes[slot] = '0;
          flow_count++;
          r.status = ST_NEW;
        end
      end
      if (r.status != ST_FULL) begin
        flow_packets[slot] += 64'd1;
        flow_bytes[slot] += 64'(len);
        r.slot = slot[7:0];
        r.packets = flow_packets[slot];
        r.bytes = flow_bytes[slot];
      end
    end
    result_q.push_back(r);
    clear_frame();
  endtask

  task automatic check_result();
    flow_result_t r;
    if (result_q.size() == 0) begin
      report("unexpected result beat, status", 64'(out_status), 64'h0);
      return;
    end
    r = result_q.pop_front();
    if (out_status !== r.status) report("status", 64'(out_status), 64'(r.status));
    if (out_flow_slot !== r.slot) report("flow_slot", 64'(out_flow_slot), 64'(r.slot));
    if (out_packet_total !== r.packets) report("packet_total", out_packet_total, r.packets);
    if (out_byte_total !== r.bytes) report("byte_total", out_byte_total, r.bytes);
    if (out_frame_length !== r.length) begin
      report("frame_length", 64'(out_frame_length), 64'(r.length));
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      flow_count = 0;
      for (int i = 0; i < FLOWS; i++) begin
        flow_packets[i] = '0;
        flow_bytes[i] = '0;
      end
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) check_result();
    end
  end
endmodule

FILE: tb/tb_five_tuple_flow_counter.sv
// Testbench top for the five-tuple flow counter: frame stimulus and verdict.
`timescale 1ns / 1ps
module tb_five_tuple_flow_counter;
  import ftfc_pkg::*;

  localparam int POOL = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_flow_slot;
  logic [63:0] out_packet_total;
  logic [63:0] out_byte_total;
  logic [15:0] out_frame_length;
  int          errors;
  int          pending;
  logic        no_idle = 1'b0;
  logic        long_hold = 1'b0;
  int          bytes_sent = 0;

  logic [31:0] pool_src[POOL];
  logic [31:0] pool_dst[POOL];
  logic [15:0] pool_sport[POOL];
  logic [15:0] pool_dport[POOL];
  logic [7:0]  pool_proto[POOL];

  five_tuple_flow_counter u_top (.*);

  ftfc_flow_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= long_hold || (!no_idle && $urandom_range(99) < 22);
  end

  initial begin
    wait (bytes_sent >= 700);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                            input logic [7:0] proto, input logic [31:0] src,
                            input logic [31:0] dst, input logic [15:0] sport,
                            input logic [15:0] dport, input int len);
    int l4;
    logic [7:0] b;
    l4 = 14 + 4 * ver_ihl[3:0];
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (i)
        12: b = etype[15:8];
        13: b = etype[7:0];
        14: b = ver_ihl;
        23: b = proto;
        default: begin
          if (i >= 26 && i <= 29) b = src[8 * (29 - i) +: 8];
          else if (i >= 30 && i <= 33) b = dst[8 * (33 - i) +: 8];
          else if (i >= 34 && i >= l4 && i <= l4 + 1) b = sport[8 * (l4 + 1 - i) +: 8];
          else if (i >= 34 && i >= l4 + 2 && i <= l4 + 3) b = dport[8 * (l4 + 3 - i) +: 8];
        end
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_random_frame();
    int p;
    int hw;
    int need;
    int len;
    logic [15:0] etype;
    p = $urandom_range(POOL - 1);
    hw = ($urandom_range(9) < 8) ? 5 : $urandom_range(15);
    need = 14 + 4 * hw + ((pool_proto[p] == PROTO_TCP) ? 20 :
                          (pool_proto[p] == PROTO_UDP) ? 8 : 0);
    if (need < 34) need = 34;
    len = need + $urandom_range(24);
    etype = IPV4_TYPE;
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: etype = 16'($urandom);
        1: len = $urandom_range(1, need);
        default: len = $urandom_range(1, 40);
      endcase
    end
    send_frame(etype, {4'($urandom), 4'(hw)}, pool_proto[p], pool_src[p], pool_dst[p],
               pool_sport[p], pool_dport[p], len);
  endtask

  task automatic drain(input int extra);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) begin
      pool_src[i] = $urandom;
      pool_dst[i] = $urandom;
      pool_sport[i] = 16'($urandom);
      pool_dport[i] = 16'($urandom);
      pool_proto[i] = (i % 3 == 0) ? PROTO_TCP : (i % 3 == 1) ? PROTO_UDP : 8'($urandom);
    end
    pool_src[0] = '1;
    pool_dst[0] = '1;
    pool_sport[0] = '1;
    pool_dport[0] = '1;
    pool_src[1] = '0;
    pool_dst[1] = '0;
    pool_sport[1] = '0;
    pool_dport[1] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(IPV4_TYPE, 8'h45, PROTO_TCP, '1, '1, '1, '1, 54);
    send_frame(IPV4_TYPE, 8'h45, PROTO_TCP, '1, '1, '1, '1, 54);
    send_frame(IPV4_TYPE, 8'h45, PROTO_TCP, '1, '1, '1, '1, 53);
    send_frame(IPV4_TYPE, 8'h45, PROTO_UDP, '0, '0, '0, '0, 42);
    send_frame(IPV4_TYPE, 8'h45, PROTO_UDP, '0, '0, '0, '0, 41);
    send_frame(IPV4_TYPE, 8'h40, 8'hFF, 32'h1, 32'h2, '0, '0, 34);
    send_frame(IPV4_TYPE, 8'h42, PROTO_UDP, 32'h3, 32'h4, '0, '0, 34);
    send_frame(IPV4_TYPE, 8'hFF, PROTO_TCP, 32'h5, 32'h6, 16'h8000, 16'h1, 94);
    send_frame(IPV4_TYPE, 8'hFF, PROTO_TCP, 32'h5, 32'h6, 16'h8000, 16'h1, 93);
    send_frame(IPV4_TYPE, 8'h45, 8'h0, 32'h7, 32'h8, '0, '0, 33);
    send_frame(16'h86DD, 8'h45, PROTO_TCP, 32'h7, 32'h8, '0, '0, 60);
    send_frame(16'h0000, 8'h00, 8'h00, '0, '0, '0, '0, 1);

    no_idle = 1'b1;
    repeat (8) send_random_frame();
    no_idle = 1'b0;
    while (bytes_sent < 1000) send_random_frame();
    drain(600);

    repeat (6) send_random_frame();
    send_frame(IPV4_TYPE, 8'h45, PROTO_TCP, '1, '1, '1, '1, 54);

    in_valid <= 1'b0;
    drain(600);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ftfc_pkg.sv
rtl/ftfc_ctrl.sv
rtl/ftfc_datapath.sv
rtl/five_tuple_flow_counter.sv
tb/ftfc_flow_checker.sv
tb/tb_five_tuple_flow_counter.sv
